// ===== rtl/cpru_pkg.sv =====
// Shared types and constants for the circle pair relation and union block.
`default_nettype none
package cpru_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = COORD_W - 1;
    localparam int MAG_W   = COORD_W;          // |c1 - c2| fits in COORD_W bits
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = MAG_W + 1;        // root of a (2*MAG_W+1)-bit sum
    localparam int NUM_W   = ROOT_W + 1;       // d + rl - rs, and 2*d
    localparam int PROD_W  = MAG_W + NUM_W;
    localparam int QUO_W   = MAG_W;            // quotient stays below |c1 - c2|

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic        [RAD_W-1:0]   first_radius;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic        [RAD_W-1:0]   second_radius;
    } t_req;

    typedef struct packed {
        logic                      inside_flag;
        logic                      overlap_flag;
        logic signed [COORD_W-1:0] union_x;
        logic signed [COORD_W-1:0] union_y;
        logic        [RAD_W-1:0]   union_radius;
        logic                      saturated_flag;
    } t_res;

    // circles after ordering: s = smaller, l = larger
    typedef struct packed {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] yl;
        logic        [RAD_W-1:0]   rs;
        logic        [RAD_W-1:0]   rl;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
    } t_sqs;

    typedef struct packed {
        logic                      nested;
        logic                      overlap;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] yl;
        logic        [RAD_W-1:0]   rl;
        logic        [RAD_W-1:0]   ur;
        logic                      rsat;
    } t_dvs;

endpackage
`default_nettype wire

// ===== rtl/cpru_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module cpru_isqrt #(
    parameter int RW     = 25,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [2*RW-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RW-1:0]          o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int RMW = RW + 2;

    logic              r_v    [0:RW-1];
    logic [2*RW-1:0]   r_rad  [0:RW-1];
    logic [RMW-1:0]    r_rem  [0:RW-1];
    logic [RW-1:0]     r_root [0:RW-1];
    logic [SIDE_W-1:0] r_side [0:RW-1];

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_stage
            logic              a_v;
            logic [2*RW-1:0]   a_rad;
            logic [RMW-1:0]    a_rem;
            logic [RW-1:0]     a_root;
            logic [SIDE_W-1:0] a_side;
            logic [RMW-1:0]    sh;
            logic [RMW-1:0]    trial;
            logic              ge;
            if (g == 0) begin : g_first
                assign a_v    = i_valid;
                assign a_rad  = i_rad;
                assign a_rem  = '0;
                assign a_root = '0;
                assign a_side = i_side;
            end else begin : g_next
                assign a_v    = r_v[g-1];
                assign a_rad  = r_rad[g-1];
                assign a_rem  = r_rem[g-1];
                assign a_root = r_root[g-1];
                assign a_side = r_side[g-1];
            end
            assign sh    = {a_rem[RMW-3:0], a_rad[2*(RW-1-g)+1 -: 2]};
            assign trial = {a_root, 2'b01};
            assign ge    = (sh >= trial);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else begin
                    r_v[g] <= a_v;
                end
                r_rad[g]  <= a_rad;
                r_rem[g]  <= ge ? sh - trial : sh;
                r_root[g] <= {a_root[RW-2:0], ge};
                r_side[g] <= a_side;
            end
        end
    endgenerate

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];
endmodule
`default_nettype wire

// ===== rtl/cpru_div.sv =====
// Pipelined restoring divider for two numerators over one divisor.
`default_nettype none
module cpru_div #(
    parameter int QW     = 24,
    parameter int DW     = 26,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [QW+DW-1:0]  i_num_x,
    input  wire logic [QW+DW-1:0]  i_num_y,
    input  wire logic [DW-1:0]     i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QW-1:0]          o_quo_x,
    output logic [QW-1:0]          o_quo_y,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int NW = QW + DW;

    logic              r_v    [0:QW-1];
    logic [NW-1:0]     r_nx   [0:QW-1];
    logic [NW-1:0]     r_ny   [0:QW-1];
    logic [DW-1:0]     r_rx   [0:QW-1];
    logic [DW-1:0]     r_ry   [0:QW-1];
    logic [QW-1:0]     r_qx   [0:QW-1];
    logic [QW-1:0]     r_qy   [0:QW-1];
    logic [DW-1:0]     r_den  [0:QW-1];
    logic [SIDE_W-1:0] r_side [0:QW-1];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_stage
            logic              a_v;
            logic [NW-1:0]     a_nx;
            logic [NW-1:0]     a_ny;
            logic [DW-1:0]     a_rx;
            logic [DW-1:0]     a_ry;
            logic [QW-1:0]     a_qx;
            logic [QW-1:0]     a_qy;
            logic [DW-1:0]     a_den;
            logic [SIDE_W-1:0] a_side;
            logic [DW:0]       shx;
            logic [DW:0]       shy;
            logic              gex;
            logic              gey;
            logic [DW:0]       subx;
            logic [DW:0]       suby;
            if (g == 0) begin : g_first
                // upper numerator bits are already below the divisor
                assign a_v    = i_valid;
                assign a_nx   = i_num_x;
                assign a_ny   = i_num_y;
                assign a_rx   = i_num_x[NW-1:QW];
                assign a_ry   = i_num_y[NW-1:QW];
                assign a_qx   = '0;
                assign a_qy   = '0;
                assign a_den  = i_den;
                assign a_side = i_side;
            end else begin : g_next
                assign a_v    = r_v[g-1];
                assign a_nx   = r_nx[g-1];
                assign a_ny   = r_ny[g-1];
                assign a_rx   = r_rx[g-1];
                assign a_ry   = r_ry[g-1];
                assign a_qx   = r_qx[g-1];
                assign a_qy   = r_qy[g-1];
                assign a_den  = r_den[g-1];
                assign a_side = r_side[g-1];
            end
            assign shx  = {a_rx, a_nx[QW-1-g]};
            assign shy  = {a_ry, a_ny[QW-1-g]};
            assign gex  = (shx >= {1'b0, a_den});
            assign gey  = (shy >= {1'b0, a_den});
            assign subx = gex ? shx - {1'b0, a_den} : shx;
            assign suby = gey ? shy - {1'b0, a_den} : shy;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else begin
                    r_v[g] <= a_v;
                end
                r_nx[g]   <= a_nx;
                r_ny[g]   <= a_ny;
                r_rx[g]   <= subx[DW-1:0];
                r_ry[g]   <= suby[DW-1:0];
                r_qx[g]   <= {a_qx[QW-2:0], gex};
                r_qy[g]   <= {a_qy[QW-2:0], gey};
                r_den[g]  <= a_den;
                r_side[g] <= a_side;
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_quo_x = r_qx[QW-1];
    assign o_quo_y = r_qy[QW-1];
    assign o_side  = r_side[QW-1];
endmodule
`default_nettype wire

// ===== rtl/circle_pair_relation_and_union.sv =====
// Top level: containment, overlap and enclosing circle of two circles.
//
//  channel   ports                       direction  marking
//  request   start, busy, i_req          in         start & !busy
//  result    o_done, o_res               out        o_done, one cycle
//
// Fully pipelined: one request per cycle.
// The pipe holds the 25-stage square root and the 24-stage divider.
// busy stays low; the result cannot be held off, so the pipe never stalls.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none
module circle_pair_relation_and_union (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cpru_pkg::t_req i_req,
    output logic                o_done,
    output cpru_pkg::t_res      o_res
);
    import cpru_pkg::*;

    localparam logic [RAD_W-1:0] RMAX = {RAD_W{1'b1}};

    // stage 1: order circles
    logic r1_v;
    t_geo r1_g;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
        end
        if (i_req.first_radius > i_req.second_radius) begin
            r1_g <= '{xs: i_req.second_x, ys: i_req.second_y, xl: i_req.first_x,
                      yl: i_req.first_y, rs: i_req.second_radius, rl: i_req.first_radius};
        end else begin
            r1_g <= '{xs: i_req.first_x, ys: i_req.first_y, xl: i_req.second_x,
                      yl: i_req.second_y, rs: i_req.first_radius, rl: i_req.second_radius};
        end
    end
    assign busy = 1'b0;

    // stage 2: centre distance magnitudes
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] adx;
    logic signed [COORD_W:0] ady;
    assign dx  = {r1_g.xs[COORD_W-1], r1_g.xs} - {r1_g.xl[COORD_W-1], r1_g.xl};
    assign dy  = {r1_g.ys[COORD_W-1], r1_g.ys} - {r1_g.yl[COORD_W-1], r1_g.yl};
    assign adx = dx[COORD_W] ? -dx : dx;
    assign ady = dy[COORD_W] ? -dy : dy;

    logic             r2_v;
    t_geo             r2_g;
    logic [MAG_W-1:0] r2_mx;
    logic [MAG_W-1:0] r2_my;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_g  <= r1_g;
        r2_mx <= adx[MAG_W-1:0];
        r2_my <= ady[MAG_W-1:0];
    end

    // stage 3: squares
    logic            r3_v;
    t_sqs            r3_s;
    logic [SQ_W-1:0] r3_sx2;
    logic [SQ_W-1:0] r3_sy2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_s   <= '{geo: r2_g, mx: r2_mx, my: r2_my};
        r3_sx2 <= r2_mx * r2_mx;
        r3_sy2 <= r2_my * r2_my;
    end

    // stage 4: sum of squares
    logic              r4_v;
    t_sqs              r4_s;
    logic [2*ROOT_W-1:0] r4_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_s   <= r3_s;
        r4_sum <= {{(2*ROOT_W-SQ_W){1'b0}}, r3_sx2} + {{(2*ROOT_W-SQ_W){1'b0}}, r3_sy2};
    end

    logic              q_v;
    logic [ROOT_W-1:0] q_d;
    logic [$bits(t_sqs)-1:0] q_side;
    t_sqs              q_s;

    cpru_isqrt #(
        .RW     (ROOT_W),
        .SIDE_W ($bits(t_sqs))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_rad   (r4_sum),
        .i_side  (r4_s),
        .o_valid (q_v),
        .o_root  (q_d),
        .o_side  (q_side)
    );
    assign q_s = t_sqs'(q_side);

    // stage 5: relations, radius, division operands
    logic [NUM_W:0] d_w;
    logic [NUM_W:0] rs_w;
    logic [NUM_W:0] rl_w;
    logic [NUM_W:0] rsum;
    assign d_w  = {2'b00, q_d};
    assign rs_w = {{(NUM_W+1-RAD_W){1'b0}}, q_s.geo.rs};
    assign rl_w = {{(NUM_W+1-RAD_W){1'b0}}, q_s.geo.rl};
    assign rsum = d_w + rs_w + rl_w;

    logic             r5_v;
    t_sqs             r5_s;
    logic             r5_in;
    logic             r5_ov;
    logic [NUM_W-1:0] r5_num;
    logic [NUM_W-1:0] r5_den;
    logic [RAD_W-1:0] r5_ur;
    logic             r5_rsat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= q_v;
        end
        r5_s    <= q_s;
        r5_in   <= (d_w + rs_w) <= rl_w;
        r5_ov   <= d_w < (rs_w + rl_w);
        r5_num  <= NUM_W'(d_w + rl_w - rs_w);
        r5_den  <= {q_d, 1'b0};
        r5_rsat <= (rsum[NUM_W:1] > {{(NUM_W-RAD_W){1'b0}}, RMAX});
        r5_ur   <= (rsum[NUM_W:1] > {{(NUM_W-RAD_W){1'b0}}, RMAX}) ? RMAX
                                                                     : rsum[RAD_W:1];
    end

    // stage 6: numerators
    logic              r6_v;
    t_dvs              r6_s;
    logic [PROD_W-1:0] r6_px;
    logic [PROD_W-1:0] r6_py;
    logic [NUM_W-1:0]  r6_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_s   <= '{nested: r5_in, overlap: r5_ov, xs: r5_s.geo.xs, ys: r5_s.geo.ys,
                    xl: r5_s.geo.xl, yl: r5_s.geo.yl, rl: r5_s.geo.rl, ur: r5_ur,
                    rsat: r5_rsat};
        r6_px  <= r5_s.mx * r5_num;
        r6_py  <= r5_s.my * r5_num;
        r6_den <= r5_den;
    end

    logic              v_v;
    logic [QUO_W-1:0]  v_qx;
    logic [QUO_W-1:0]  v_qy;
    logic [$bits(t_dvs)-1:0] v_side;
    t_dvs              v_s;

    cpru_div #(
        .QW     (QUO_W),
        .DW     (NUM_W),
        .SIDE_W ($bits(t_dvs))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_num_x (r6_px),
        .i_num_y (r6_py),
        .i_den   (r6_den),
        .i_side  (r6_s),
        .o_valid (v_v),
        .o_quo_x (v_qx),
        .o_quo_y (v_qy),
        .o_side  (v_side)
    );
    assign v_s = t_dvs'(v_side);

    // final stage: place centre, clip, select
    logic signed [COORD_W+1:0] cx;
    logic signed [COORD_W+1:0] cy;
    logic signed [COORD_W+1:0] cmax;
    logic signed [COORD_W+1:0] cmin;
    logic                      satx;
    logic                      saty;
    logic signed [COORD_W-1:0] ux;
    logic signed [COORD_W-1:0] uy;
    assign cmax = (COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}});
    assign cmin = -cmax - (COORD_W+2)'(1);
    always_comb begin
        cx = (v_s.xl < v_s.xs)
           ? (COORD_W+2)'(v_s.xs) - (COORD_W+2)'({1'b0, v_qx})
           : (COORD_W+2)'(v_s.xs) + (COORD_W+2)'({1'b0, v_qx});
        cy = (v_s.yl < v_s.ys)
           ? (COORD_W+2)'(v_s.ys) - (COORD_W+2)'({1'b0, v_qy})
           : (COORD_W+2)'(v_s.ys) + (COORD_W+2)'({1'b0, v_qy});
        satx = (cx > cmax) || (cx < cmin);
        saty = (cy > cmax) || (cy < cmin);
        ux = (cx > cmax) ? cmax[COORD_W-1:0] : (cx < cmin) ? cmin[COORD_W-1:0]
                                                            : cx[COORD_W-1:0];
        uy = (cy > cmax) ? cmax[COORD_W-1:0] : (cy < cmin) ? cmin[COORD_W-1:0]
                                                            : cy[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= v_v;
        end
        o_res.inside_flag  <= v_s.nested;
        o_res.overlap_flag <= v_s.overlap;
        if (v_s.nested) begin
            o_res.union_x        <= v_s.xl;
            o_res.union_y        <= v_s.yl;
            o_res.union_radius   <= v_s.rl;
            o_res.saturated_flag <= 1'b0;
        end else begin
            o_res.union_x        <= ux;
            o_res.union_y        <= uy;
            o_res.union_radius   <= v_s.ur;
            o_res.saturated_flag <= v_s.rsat | satx | saty;
        end
    end
endmodule
`default_nettype wire
